>>> src/osset_pkg.sv
package osset_pkg;

    // field widths fixed by the command and result formats
    localparam int KEY_W  = 32;
    localparam int RANK_W = 7;
    localparam int CMD_W  = 2;
    localparam int STAT_W = 2;
    localparam int CNT_W  = 7;

    // command codes
    localparam logic [CMD_W-1:0] CMD_INSERT = 2'd0;
    localparam logic [CMD_W-1:0] CMD_DELETE = 2'd1;
    localparam logic [CMD_W-1:0] CMD_QUERY  = 2'd2;

    // result status codes
    localparam logic [STAT_W-1:0] STAT_DONE     = 2'd0;
    localparam logic [STAT_W-1:0] STAT_NOCHANGE = 2'd1;
    localparam logic [STAT_W-1:0] STAT_FULL     = 2'd2;
    localparam logic [STAT_W-1:0] STAT_RANGE    = 2'd3;

    // commands from the controller to the datapath
    typedef struct packed {
        logic start;       // latch the command, open the search window
        logic rd_mid;      // read the middle entry of the window
        logic cmp_mid;     // narrow the window from the read data
        logic rd_probe;    // read the entry at the found position or rank
        logic cap_data;    // capture the probed entry
        logic shift_init;  // load the shift pointer
        logic shift_step;  // move one entry
        logic finish;      // commit and load the result register
    } dp_cmd_t;

    // status from the datapath to the controller
    typedef struct packed {
        logic [CMD_W-1:0] op;
        logic             search_done;
        logic             present;
        logic             full;
        logic             shift_needed;
        logic             shift_last;
        logic             out_free;
    } dp_stat_t;

endpackage

>>> src/order_statistic_set_unit.sv
// order statistic set: a sorted set of distinct signed 32-bit keys
//
// input channel (s_): one command per transfer, s_tuser holds the command
// code (insert, delete, query k-th smallest), s_tdata holds key and rank.
// result channel (m_): exactly one result per command with status, the
// key found by a successful query (else zero) and the entry count after
// the command.
//
// keys sit in ascending order in a single-port-write, registered-read
// memory of CAPACITY words. insert and delete run a binary search (a
// middle read, then a narrowing per halving step), then shift the tail
// one entry per cycle. with n keys held and p the found position:
//   query          no search; an unused command code goes straight to commit
//   insert/delete  at most ceil(log2(n+1)) search steps,
//                  then n - p entries moved by insert,
//                  n - p - 1 by delete
// one command is worked on at a time; s_tready is high only when idle.
// the result waits in an output register: a stalled receiver holds the
// block in its commit step until m_tready frees the register.
// reset clears the set (entry count zero) and drops any pending result;
// the key memory itself is not cleared.
module order_statistic_set_unit #(
    parameter int CAPACITY = 64
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [39:0] s_tdata,   // key[31:0], rank[38:32], zero pad
    input  logic [1:0]  s_tuser,   // cmd[1:0]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [47:0] m_tdata    // status[1:0], kth_key[33:2], entry_count[40:34], zero pad
);

    osset_pkg::dp_cmd_t  cmd;
    osset_pkg::dp_stat_t stat;

    logic [osset_pkg::STAT_W-1:0]       out_status;
    logic signed [osset_pkg::KEY_W-1:0] out_key;
    logic [osset_pkg::CNT_W-1:0]        out_count;

    // sequencer
    osset_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    // key store, search and result register
    osset_dp #(
        .CAPACITY (CAPACITY)
    ) u_dp (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .in_cmd     (s_tuser),
        .in_key     ($signed(s_tdata[31:0])),
        .in_rank    (s_tdata[38:32]),
        .cmd        (cmd),
        .stat       (stat),
        .m_tready   (m_tready),
        .m_tvalid   (m_tvalid),
        .out_status (out_status),
        .out_key    (out_key),
        .out_count  (out_count)
    );

    // pack result fields, lowest first
    assign m_tdata = {7'd0, out_count, out_key, out_status};

endmodule

>>> src/osset_ctrl.sv
module osset_ctrl (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_tvalid,
    output logic                s_tready,
    input  osset_pkg::dp_stat_t stat,
    output osset_pkg::dp_cmd_t  cmd
);

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_SRCH,
        ST_SWAIT,
        ST_PROBE,
        ST_PWAIT,
        ST_DECIDE,
        ST_SHIFT,
        ST_DRAIN,
        ST_FIN
    } state_t;

    state_t state_reg;
    state_t state_next;

    assign s_tready = (state_reg == ST_IDLE);

    // next state and datapath commands
    always_comb begin
        cmd        = '0;
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) begin
                    cmd.start  = 1'b1;
                    state_next = ST_SRCH;
                end
            end
            ST_SRCH: begin
                if (stat.op == osset_pkg::CMD_QUERY) begin
                    state_next = ST_PROBE;
                end else if (stat.op != osset_pkg::CMD_INSERT &&
                             stat.op != osset_pkg::CMD_DELETE) begin
                    state_next = ST_FIN;
                end else if (stat.search_done) begin
                    state_next = ST_PROBE;
                end else begin
                    cmd.rd_mid = 1'b1;
                    state_next = ST_SWAIT;
                end
            end
            ST_SWAIT: begin
                cmd.cmp_mid = 1'b1;
                state_next  = ST_SRCH;
            end
            ST_PROBE: begin
                cmd.rd_probe = 1'b1;
                state_next   = ST_PWAIT;
            end
            ST_PWAIT: begin
                cmd.cap_data = 1'b1;
                state_next   = ST_DECIDE;
            end
            ST_DECIDE: begin
                if (stat.op == osset_pkg::CMD_INSERT && !stat.present &&
                    !stat.full && stat.shift_needed) begin
                    cmd.shift_init = 1'b1;
                    state_next     = ST_SHIFT;
                end else if (stat.op == osset_pkg::CMD_DELETE && stat.present &&
                             stat.shift_needed) begin
                    cmd.shift_init = 1'b1;
                    state_next     = ST_SHIFT;
                end else begin
                    state_next = ST_FIN;
                end
            end
            ST_SHIFT: begin
                cmd.shift_step = 1'b1;
                if (stat.shift_last) begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN: begin
                // last moved entry is written in this cycle
                state_next = ST_FIN;
            end
            ST_FIN: begin
                if (stat.out_free) begin
                    cmd.finish = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // state register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

endmodule

>>> src/osset_dp.sv
module osset_dp #(
    parameter int CAPACITY = 64
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic [osset_pkg::CMD_W-1:0]         in_cmd,
    input  logic signed [osset_pkg::KEY_W-1:0]  in_key,
    input  logic [osset_pkg::RANK_W-1:0]        in_rank,
    input  osset_pkg::dp_cmd_t                  cmd,
    output osset_pkg::dp_stat_t                 stat,
    input  logic                                m_tready,
    output logic                                m_tvalid,
    output logic [osset_pkg::STAT_W-1:0]        out_status,
    output logic signed [osset_pkg::KEY_W-1:0]  out_key,
    output logic [osset_pkg::CNT_W-1:0]         out_count
);

    localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CW = $clog2(CAPACITY + 1);
    localparam int MW = (CW > osset_pkg::RANK_W) ? CW : osset_pkg::RANK_W;

    // key store, read data registered
    logic [osset_pkg::KEY_W-1:0] mem [CAPACITY];
    logic [osset_pkg::KEY_W-1:0] rd_q;
    logic [AW-1:0]               rd_addr;
    logic                        wr_en;
    logic [AW-1:0]               wr_addr;
    logic [osset_pkg::KEY_W-1:0] wr_data;

    logic [osset_pkg::CMD_W-1:0]        op_reg;
    logic signed [osset_pkg::KEY_W-1:0] key_reg;
    logic [osset_pkg::RANK_W-1:0]       rank_reg;
    logic [CW-1:0]                      lo_reg;
    logic [CW-1:0]                      hi_reg;
    logic [CW-1:0]                      count_reg;
    logic [osset_pkg::KEY_W-1:0]        data_reg;
    logic [AW-1:0]                      ptr_reg;
    logic                               move_v_reg;
    logic [AW-1:0]                      move_dst_reg;

    logic                               m_valid_reg;
    logic [osset_pkg::STAT_W-1:0]       m_status_reg;
    logic signed [osset_pkg::KEY_W-1:0] m_key_reg;
    logic [osset_pkg::CNT_W-1:0]        m_count_reg;

    logic [CW-1:0]                      mid;
    logic                               present;
    logic                               full;
    logic                               range_bad;
    logic                               ins_ok;
    logic                               is_ins;
    logic [osset_pkg::STAT_W-1:0]       res_status;
    logic signed [osset_pkg::KEY_W-1:0] res_key;
    logic [CW-1:0]                      count_new;

    // search window midpoint and item checks
    assign mid       = lo_reg + ((hi_reg - lo_reg) >> 1);
    assign is_ins    = (op_reg == osset_pkg::CMD_INSERT);
    assign present   = (lo_reg < count_reg) && (data_reg == key_reg);
    assign full      = (count_reg >= CW'(CAPACITY));
    assign range_bad = (rank_reg == '0) || (MW'(rank_reg) > MW'(count_reg));
    assign ins_ok    = !present && !full;

    // status to the controller
    always_comb begin
        stat.op          = op_reg;
        stat.search_done = (lo_reg == hi_reg);
        stat.present     = present;
        stat.full        = full;
        stat.shift_needed = is_ins ? (lo_reg < count_reg)
                                   : ((lo_reg + CW'(1)) < count_reg);
        stat.shift_last  = is_ins ? (ptr_reg == AW'(lo_reg))
                                  : (ptr_reg == AW'(count_reg - CW'(1)));
        stat.out_free    = !m_valid_reg || m_tready;
    end

    // result of the command
    always_comb begin
        res_status = osset_pkg::STAT_NOCHANGE;
        res_key    = '0;
        count_new  = count_reg;
        case (op_reg)
            osset_pkg::CMD_INSERT: begin
                if (present) begin
                    res_status = osset_pkg::STAT_NOCHANGE;
                end else if (full) begin
                    res_status = osset_pkg::STAT_FULL;
                end else begin
                    res_status = osset_pkg::STAT_DONE;
                    count_new  = count_reg + CW'(1);
                end
            end
            osset_pkg::CMD_DELETE: begin
                if (present) begin
                    res_status = osset_pkg::STAT_DONE;
                    count_new  = count_reg - CW'(1);
                end
            end
            osset_pkg::CMD_QUERY: begin
                if (range_bad) begin
                    res_status = osset_pkg::STAT_RANGE;
                end else begin
                    res_status = osset_pkg::STAT_DONE;
                    res_key    = data_reg;
                end
            end
            default: begin
                res_status = osset_pkg::STAT_NOCHANGE;
            end
        endcase
    end

    // read address select
    always_comb begin
        rd_addr = ptr_reg;
        if (cmd.rd_mid) begin
            rd_addr = AW'(mid);
        end else if (cmd.rd_probe) begin
            if (op_reg == osset_pkg::CMD_QUERY) begin
                rd_addr = AW'(rank_reg - osset_pkg::RANK_W'(1));
            end else begin
                rd_addr = AW'(lo_reg);
            end
        end
    end

    // write port: moved entry, or new key on insert commit
    always_comb begin
        wr_en   = 1'b0;
        wr_addr = move_dst_reg;
        wr_data = rd_q;
        if (move_v_reg) begin
            wr_en = 1'b1;
        end else if (cmd.finish && is_ins && ins_ok) begin
            wr_en   = 1'b1;
            wr_addr = AW'(lo_reg);
            wr_data = key_reg;
        end
    end

    // key store
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        rd_q <= mem[rd_addr];
    end

    // search, probe and shift registers
    always_ff @(posedge aclk) begin
        if (cmd.start) begin
            op_reg   <= in_cmd;
            key_reg  <= in_key;
            rank_reg <= in_rank;
            lo_reg   <= '0;
            hi_reg   <= count_reg;
        end
        if (cmd.cmp_mid) begin
            if ($signed(rd_q) < key_reg) begin
                lo_reg <= mid + CW'(1);
            end else begin
                hi_reg <= mid;
            end
        end
        if (cmd.cap_data) begin
            data_reg <= rd_q;
        end
        if (cmd.shift_init) begin
            ptr_reg <= is_ins ? AW'(count_reg - CW'(1)) : AW'(lo_reg + CW'(1));
        end else if (cmd.shift_step) begin
            ptr_reg <= is_ins ? (ptr_reg - AW'(1)) : (ptr_reg + AW'(1));
        end
        move_dst_reg <= is_ins ? (ptr_reg + AW'(1)) : (ptr_reg - AW'(1));
        if (cmd.finish) begin
            m_status_reg <= res_status;
            m_key_reg    <= res_key;
            m_count_reg  <= osset_pkg::CNT_W'(count_new);
        end
    end

    // control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg   <= '0;
            move_v_reg  <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            move_v_reg <= cmd.shift_step;
            if (cmd.finish) begin
                count_reg   <= count_new;
                m_valid_reg <= 1'b1;
            end else if (m_tready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    assign m_tvalid   = m_valid_reg;
    assign out_status = m_status_reg;
    assign out_key    = m_key_reg;
    assign out_count  = m_count_reg;

`ifndef SYNTH
    // set never grows past its capacity
    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CW'(CAPACITY))
        else $error("entry count above capacity");

    // search window stays ordered and inside the set
    a_window: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.cmp_mid |-> (lo_reg < hi_reg) && (hi_reg <= count_reg))
        else $error("search window out of order");

    // a moved entry and the inserted key never share the write port
    a_wr_conflict: assert property (@(posedge aclk) disable iff (!aresetn)
        !(move_v_reg && cmd.finish))
        else $error("write port conflict");

    // commit only into a free result register, which then holds a result
    a_commit: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.finish |-> (!m_valid_reg || m_tready) ##1 m_valid_reg)
        else $error("result register overrun");

    // count changes by at most one and only on commit
    a_count_step: assert property (@(posedge aclk) disable iff (!aresetn)
        !cmd.finish |=> $stable(count_reg))
        else $error("entry count changed outside commit");
`endif

endmodule
